### hdl/mgfe_pkg.sv
// mgfe_pkg: shared types, codes and constants of the gain fade engine
// used by the controller, the datapath, the divider and the top level
`timescale 1ns / 1ps

package mgfe_pkg;

   localparam int CHANNELS_DEFAULT = 16;

   localparam int GAIN_W     = 16;
   localparam int STEP_W     = 17;
   localparam int FUNC_W     = 3;
   localparam int CHAN_W     = 4;
   localparam int KIND_W     = 2;
   localparam int TICKS_W    = 16;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int DIV_W      = 16;
   localparam int MUL_W      = 32;
   localparam int FRAC_BITS  = 15;

   localparam logic [GAIN_W-1:0] UNITY = 16'h8000;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK          = 3'd0,
      FUNC_FADE_OUT      = 3'd1,
      FUNC_FADE_OUT_STOP = 3'd2,
      FUNC_FADE_UP       = 3'd3,
      FUNC_PLAY_FADE_UP  = 3'd4,
      FUNC_SET_GAIN      = 3'd5
   } func_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_GAIN = 2'd0,
      KIND_STOP = 2'd1,
      KIND_PLAY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_OUT  = 2'd1,
      MODE_UP   = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GLOBAL_GAIN     = 1'b0,
      CSR_CHANNELS_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_GAIN_SQ,
      MUL_GLOBAL_SQ,
      MUL_PRODUCT
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_FADE_WR,
      ST_CUE,
      ST_STEP,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_SEND,
      ST_RESEND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        load;
      logic        div_start;
      logic        fade_write;
      logic        set_gain;
      logic        step_commit;
      mul_sel_type mul_sel;
      logic        emit;
      kind_type    emit_kind;
      logic        emit_cue;
      logic        flush;
      logic        advance;
      logic        sync_global;
   } dp_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              ch_ok;
      logic              cue_ok;
      logic              count_zero;
      logic              walk_last;
      logic              step_stop;
      logic              step_emit;
      logic              gain_flag;
      logic              resend_flag;
      logic              div_done;
      logic              push_ok;
      logic              flush_ok;
      logic              pend_valid;
   } dp_status_type;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      kind_type          kind;
      logic [GAIN_W-1:0] gain;
   } rsp_item_type;

   function automatic logic [GAIN_W-1:0] sat_gain(input logic [GAIN_W-1:0] v);
      return (v > UNITY) ? UNITY : v;
   endfunction

endpackage

### hdl/mgfe_req_if.sv
// mgfe_req_if: command channel of the gain fade engine
// payload widths come from mgfe_pkg
`timescale 1ns / 1ps

interface mgfe_req_if;
   logic                          valid;
   logic                          ready;
   logic [mgfe_pkg::FUNC_W-1:0]   func;
   logic [mgfe_pkg::CHAN_W-1:0]   channel;
   logic [mgfe_pkg::TICKS_W-1:0]  fade_ticks;
   logic [mgfe_pkg::GAIN_W-1:0]   target_gain;
   logic [mgfe_pkg::GAIN_W-1:0]   new_gain;
   logic                          cue_valid;
   logic [mgfe_pkg::CHAN_W-1:0]   cue_channel;

   modport source (output valid, func, channel, fade_ticks, target_gain, new_gain,
                   cue_valid, cue_channel, input ready);
   modport sink (input valid, func, channel, fade_ticks, target_gain, new_gain,
                 cue_valid, cue_channel, output ready);
endinterface

### hdl/mgfe_rsp_if.sv
// mgfe_rsp_if: result channel of the gain fade engine
// payload widths come from mgfe_pkg
`timescale 1ns / 1ps

interface mgfe_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mgfe_pkg::CHAN_W-1:0]  out_channel;
   logic [mgfe_pkg::KIND_W-1:0]  out_kind;
   logic [mgfe_pkg::GAIN_W-1:0]  out_gain;
   logic                         out_last;

   modport source (output valid, out_channel, out_kind, out_gain, out_last, input ready);
   modport sink (input valid, out_channel, out_kind, out_gain, out_last, output ready);
endinterface

### hdl/mgfe_csr_if.sv
// mgfe_csr_if: register write channel of the gain fade engine
// widths come from mgfe_pkg
`timescale 1ns / 1ps

interface mgfe_csr_if;
   logic                             valid;
   logic                             ready;
   logic [mgfe_pkg::CSR_IDX_W-1:0]   index;
   logic [mgfe_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/multichannel_gain_fade_engine_top.sv
// Sequence: a command is taken, then decoded; a fade starts the divider, writes the channel
// and sends its cue; set gain makes three passes through the shared 16x16 multiplier; then finish.
// A tick walks the channels in use; each channel that sends also passes through the multiplier.
// One item at a time: the next command is taken only after finish; result stalls hold it back.
// Reset (synchronous): all channels idle at unity gain, global gain unity, no channels walked.
`timescale 1ns / 1ps

module multichannel_gain_fade_engine_top #(
   parameter int CHANNELS = mgfe_pkg::CHANNELS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   mgfe_req_if.sink     req_bus,
   mgfe_rsp_if.source   rsp_bus,
   mgfe_csr_if.sink     csr_bus
);

   mgfe_pkg::dp_cmd_type    cmd;
   mgfe_pkg::dp_status_type status;

   mgfe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mgfe_datapath #(
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .in_func        (req_bus.func),
      .in_channel     (req_bus.channel),
      .in_fade_ticks  (req_bus.fade_ticks),
      .in_target_gain (req_bus.target_gain),
      .in_new_gain    (req_bus.new_gain),
      .in_cue_valid   (req_bus.cue_valid),
      .in_cue_channel (req_bus.cue_channel),
      .csr_valid      (csr_bus.valid),
      .csr_ready      (csr_bus.ready),
      .csr_index      (csr_bus.index),
      .csr_data       (csr_bus.data),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .out_channel    (rsp_bus.out_channel),
      .out_kind       (rsp_bus.out_kind),
      .out_gain       (rsp_bus.out_gain),
      .out_last       (rsp_bus.out_last)
   );

endmodule

### hdl/mgfe_div.sv
// mgfe_div: restoring divider, one quotient bit per cycle
// depends on mgfe_pkg for the operand width
`timescale 1ns / 1ps

module mgfe_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [mgfe_pkg::DIV_W-1:0]  dividend,
   input  logic [mgfe_pkg::DIV_W-1:0]  divisor,
   output logic                        done,
   output logic [mgfe_pkg::DIV_W-1:0]  quotient
);

   localparam int DW    = mgfe_pkg::DIV_W;
   localparam int CNT_W = $clog2(DW + 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [DW-1:0]    dvs_ff, dvs_in;
   logic [DW:0]      shifted;
   logic [DW:0]      diff;
   logic             fits;

   assign shifted = {rem_ff, quo_ff[DW-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = shifted >= {1'b0, dvs_ff};

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      if (start) begin
         cnt_in = CNT_W'(DW);
         rem_in = '0;
         quo_in = dividend;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_W'(1);
         rem_in = fits ? diff[DW-1:0] : shifted[DW-1:0];
         quo_in = {quo_ff[DW-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = (cnt_ff == '0);
   assign quotient = quo_ff;

endmodule

### hdl/mgfe_datapath.sv
// mgfe_datapath: channel state, config registers, shared multiplier, divider,
// and the result queue; driven by mgfe_ctrl through mgfe_pkg command/status types
`timescale 1ns / 1ps

module mgfe_datapath #(
   parameter int CHANNELS = mgfe_pkg::CHANNELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mgfe_pkg::dp_cmd_type              cmd,
   output mgfe_pkg::dp_status_type           status,
   input  logic [mgfe_pkg::FUNC_W-1:0]       in_func,
   input  logic [mgfe_pkg::CHAN_W-1:0]       in_channel,
   input  logic [mgfe_pkg::TICKS_W-1:0]      in_fade_ticks,
   input  logic [mgfe_pkg::GAIN_W-1:0]       in_target_gain,
   input  logic [mgfe_pkg::GAIN_W-1:0]       in_new_gain,
   input  logic                              in_cue_valid,
   input  logic [mgfe_pkg::CHAN_W-1:0]       in_cue_channel,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mgfe_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mgfe_pkg::CSR_DATA_W-1:0]   csr_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mgfe_pkg::CHAN_W-1:0]       out_channel,
   output logic [mgfe_pkg::KIND_W-1:0]       out_kind,
   output logic [mgfe_pkg::GAIN_W-1:0]       out_gain,
   output logic                              out_last
);

   localparam int IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int GW      = mgfe_pkg::GAIN_W;
   localparam int SW      = mgfe_pkg::STEP_W;
   localparam int CW      = mgfe_pkg::COUNT_W;
   localparam int FRAC    = mgfe_pkg::FRAC_BITS;
   localparam logic [CW-1:0] CHAN_COUNT = CW'(CHANNELS);

   // per-channel state
   logic [GW-1:0]           gain_ff   [CHANNELS];
   logic [SW-1:0]           step_ff   [CHANNELS];
   logic [GW-1:0]           target_ff [CHANNELS];
   mgfe_pkg::mode_type      mode_ff   [CHANNELS];
   logic                    stop_ff   [CHANNELS];

   // config and global state
   logic [GW-1:0]  gg_ff, gg_in;
   logic [CW-1:0]  chans_ff, chans_in;
   logic [GW-1:0]  last_gg_ff, last_gg_in;

   // latched command
   logic [mgfe_pkg::FUNC_W-1:0]  func_ff, func_in;
   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic                         ch_ok_ff, ch_ok_in;
   logic                         cue_ok_ff, cue_ok_in;
   logic [mgfe_pkg::CHAN_W-1:0]  cue_ch_ff, cue_ch_in;
   logic [mgfe_pkg::TICKS_W-1:0] ticks_ff, ticks_in;
   logic [GW-1:0]                cmd_tgt_ff, cmd_tgt_in;
   logic [GW-1:0]                cmd_gain_ff, cmd_gain_in;

   logic gain_flag_ff, gain_flag_in;
   logic resend_flag_ff, resend_flag_in;

   // multiplier
   logic [mgfe_pkg::MUL_W-1:0] prod_ff, prod_in;
   logic [GW-1:0]              p_ff, p_in;
   logic [GW-1:0]              mul_a, mul_b;
   logic [mgfe_pkg::MUL_W-1:0] mul_res;
   logic [GW-1:0]              scaled;

   // result queue: one pending item plus the output register
   mgfe_pkg::rsp_item_type pend_item_ff, pend_item_in;
   logic                   pend_valid_ff, pend_valid_in;
   mgfe_pkg::rsp_item_type out_item_ff, out_item_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_last_ff, out_last_in;
   mgfe_pkg::rsp_item_type emit_item;

   // current entry and tick update
   logic [GW-1:0]           cur_gain, cur_tgt;
   logic [SW-1:0]           cur_step;
   mgfe_pkg::mode_type      cur_mode;
   logic                    cur_stop;
   logic signed [SW:0]      sum;
   logic [GW-1:0]           nxt_gain;
   mgfe_pkg::mode_type      nxt_mode;
   logic                    nxt_stop;
   logic                    stop_hit;
   logic                    emits_gain;
   logic                    resend;
   logic                    changed;
   logic [CW-1:0]           count_sat;

   // divider and fade setup
   logic                    is_out;
   logic [GW-1:0]           div_amount;
   logic [GW-1:0]           div_divisor;
   logic                    div_done;
   logic [GW-1:0]           quo;
   logic [GW-1:0]           step_mag;
   logic [SW-1:0]           new_step;

   assign cur_gain = gain_ff[addr_ff];
   assign cur_tgt  = target_ff[addr_ff];
   assign cur_step = step_ff[addr_ff];
   assign cur_mode = mode_ff[addr_ff];
   assign cur_stop = stop_ff[addr_ff];

   assign changed   = (gg_ff != last_gg_ff);
   assign count_sat = (chans_ff > CHAN_COUNT) ? CHAN_COUNT : chans_ff;

   assign sum = $signed({2'b00, cur_gain}) + $signed({cur_step[SW-1], cur_step});

   always_comb begin
      nxt_gain   = cur_gain;
      nxt_mode   = cur_mode;
      nxt_stop   = cur_stop;
      stop_hit   = 1'b0;
      emits_gain = 1'b0;
      case (cur_mode)
         mgfe_pkg::MODE_OUT: begin
            emits_gain = 1'b1;
            if (sum <= $signed((SW+1)'(0))) begin
               nxt_gain = '0;
               nxt_mode = mgfe_pkg::MODE_IDLE;
               if (cur_stop) begin
                  stop_hit = 1'b1;
                  nxt_stop = 1'b0;
               end
            end else begin
               nxt_gain = sum[GW-1:0];
            end
         end
         mgfe_pkg::MODE_UP: begin
            emits_gain = 1'b1;
            if (sum >= $signed({2'b00, cur_tgt})) begin
               nxt_gain = cur_tgt;
               nxt_mode = mgfe_pkg::MODE_IDLE;
            end else begin
               nxt_gain = sum[GW-1:0];
            end
         end
         default: begin
         end
      endcase
      resend = changed && (nxt_mode != mgfe_pkg::MODE_OUT) && (nxt_mode != mgfe_pkg::MODE_UP);
   end

   // divider: start gain for a fade-out, target for a fade-up
   assign is_out = (func_ff == mgfe_pkg::FUNC_FADE_OUT) ||
                   (func_ff == mgfe_pkg::FUNC_FADE_OUT_STOP);
   assign div_amount  = is_out ? cur_gain : cmd_tgt_ff;
   assign div_divisor = (ticks_ff == '0) ? GW'(1) : ticks_ff;

   mgfe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_amount),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (quo)
   );

   assign step_mag = (quo == '0) ? GW'(1) : quo;
   assign new_step = is_out ? (~{1'b0, step_mag} + SW'(1)) : {1'b0, step_mag};

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         mgfe_pkg::MUL_GAIN_SQ: begin
            mul_a = cur_gain;
            mul_b = cur_gain;
         end
         mgfe_pkg::MUL_GLOBAL_SQ: begin
            mul_a = gg_ff;
            mul_b = gg_ff;
         end
         mgfe_pkg::MUL_PRODUCT: begin
            mul_a = p_ff;
            mul_b = scaled;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_res = mgfe_pkg::MUL_W'(mul_a) * mgfe_pkg::MUL_W'(mul_b);
   assign scaled  = prod_ff[FRAC+GW-1:FRAC];

   always_comb begin
      prod_in = prod_ff;
      p_in    = p_ff;
      if (cmd.mul_sel != mgfe_pkg::MUL_NONE) begin
         prod_in = mul_res;
      end
      if (cmd.mul_sel == mgfe_pkg::MUL_GLOBAL_SQ) begin
         p_in = scaled;
      end
   end

   // config, command latch, walk index and flags
   assign csr_ready = 1'b1;

   always_comb begin
      gg_in          = gg_ff;
      chans_in       = chans_ff;
      last_gg_in     = last_gg_ff;
      func_in        = func_ff;
      addr_in        = addr_ff;
      ch_ok_in       = ch_ok_ff;
      cue_ok_in      = cue_ok_ff;
      cue_ch_in      = cue_ch_ff;
      ticks_in       = ticks_ff;
      cmd_tgt_in     = cmd_tgt_ff;
      cmd_gain_in    = cmd_gain_ff;
      gain_flag_in   = gain_flag_ff;
      resend_flag_in = resend_flag_ff;

      if (csr_valid) begin
         case (csr_index)
            mgfe_pkg::CSR_GLOBAL_GAIN:     gg_in = mgfe_pkg::sat_gain(csr_data);
            mgfe_pkg::CSR_CHANNELS_IN_USE: chans_in = csr_data[CW-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.load) begin
         func_in     = in_func;
         addr_in     = (in_func == mgfe_pkg::FUNC_TICK) ? '0 : IDX_W'(in_channel);
         ch_ok_in    = 32'(in_channel) < CHANNELS;
         cue_ok_in   = in_cue_valid && (32'(in_cue_channel) < CHANNELS);
         cue_ch_in   = in_cue_channel;
         ticks_in    = in_fade_ticks;
         cmd_tgt_in  = mgfe_pkg::sat_gain(in_target_gain);
         cmd_gain_in = mgfe_pkg::sat_gain(in_new_gain);
      end else if (cmd.advance) begin
         addr_in = addr_ff + IDX_W'(1);
      end

      if (cmd.sync_global) begin
         last_gg_in = gg_ff;
      end

      if (cmd.set_gain) begin
         gain_flag_in   = 1'b1;
         resend_flag_in = 1'b0;
      end else if (cmd.step_commit) begin
         gain_flag_in   = emits_gain;
         resend_flag_in = resend;
      end
   end

   // result queue
   assign emit_item.chan = cmd.emit_cue ? cue_ch_ff : mgfe_pkg::CHAN_W'(addr_ff);
   assign emit_item.kind = cmd.emit_kind;
   assign emit_item.gain = (cmd.emit_kind == mgfe_pkg::KIND_GAIN) ? scaled : '0;

   always_comb begin
      pend_item_in  = pend_item_ff;
      pend_valid_in = pend_valid_ff;
      out_item_in   = out_item_ff;
      out_valid_in  = out_valid_ff;
      out_last_in   = out_last_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         // the held item is known not to be last once another one arrives
         if (pend_valid_ff) begin
            out_item_in  = pend_item_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_item_in  = emit_item;
         pend_valid_in = 1'b1;
      end else if (cmd.flush && pend_valid_ff) begin
         out_item_in   = pend_item_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gg_ff          <= mgfe_pkg::UNITY;
         chans_ff       <= '0;
         last_gg_ff     <= '0;
         func_ff        <= mgfe_pkg::FUNC_TICK;
         addr_ff        <= '0;
         ch_ok_ff       <= 1'b0;
         cue_ok_ff      <= 1'b0;
         gain_flag_ff   <= 1'b0;
         resend_flag_ff <= 1'b0;
         pend_valid_ff  <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         gg_ff          <= gg_in;
         chans_ff       <= chans_in;
         last_gg_ff     <= last_gg_in;
         func_ff        <= func_in;
         addr_ff        <= addr_in;
         ch_ok_ff       <= ch_ok_in;
         cue_ok_ff      <= cue_ok_in;
         gain_flag_ff   <= gain_flag_in;
         resend_flag_ff <= resend_flag_in;
         pend_valid_ff  <= pend_valid_in;
         out_valid_ff   <= out_valid_in;
      end
      cue_ch_ff    <= cue_ch_in;
      ticks_ff     <= ticks_in;
      cmd_tgt_ff   <= cmd_tgt_in;
      cmd_gain_ff  <= cmd_gain_in;
      prod_ff      <= prod_in;
      p_ff         <= p_in;
      pend_item_ff <= pend_item_in;
      out_item_ff  <= out_item_in;
      out_last_ff  <= out_last_in;
   end

   // channel state, one entry written per cycle at the current address
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            gain_ff[i]   <= mgfe_pkg::UNITY;
            step_ff[i]   <= '0;
            target_ff[i] <= mgfe_pkg::UNITY;
            mode_ff[i]   <= mgfe_pkg::MODE_IDLE;
            stop_ff[i]   <= 1'b0;
         end
      end else begin
         if (cmd.fade_write) begin
            step_ff[addr_ff] <= new_step;
            if (is_out) begin
               mode_ff[addr_ff] <= mgfe_pkg::MODE_OUT;
               stop_ff[addr_ff] <= (func_ff == mgfe_pkg::FUNC_FADE_OUT_STOP);
            end else begin
               mode_ff[addr_ff]   <= mgfe_pkg::MODE_UP;
               stop_ff[addr_ff]   <= 1'b0;
               target_ff[addr_ff] <= cmd_tgt_ff;
            end
         end
         if (cmd.set_gain) begin
            gain_ff[addr_ff] <= cmd_gain_ff;
         end
         if (cmd.step_commit) begin
            gain_ff[addr_ff] <= nxt_gain;
            mode_ff[addr_ff] <= nxt_mode;
            stop_ff[addr_ff] <= nxt_stop;
         end
      end
   end

   assign status.func        = func_ff;
   assign status.ch_ok       = ch_ok_ff;
   assign status.cue_ok      = cue_ok_ff;
   assign status.count_zero  = (count_sat == '0);
   assign status.walk_last   = ((CW'(addr_ff) + CW'(1)) == count_sat);
   assign status.step_stop   = stop_hit;
   assign status.step_emit   = emits_gain || resend;
   assign status.gain_flag   = gain_flag_ff;
   assign status.resend_flag = resend_flag_ff;
   assign status.div_done    = div_done;
   assign status.push_ok     = !pend_valid_ff || !out_valid_ff || rsp_ready;
   assign status.flush_ok    = !out_valid_ff || rsp_ready;
   assign status.pend_valid  = pend_valid_ff;

   assign rsp_valid   = out_valid_ff;
   assign out_channel = out_item_ff.chan;
   assign out_kind    = out_item_ff.kind;
   assign out_gain    = out_item_ff.gain;
   assign out_last    = out_last_ff;

endmodule

### hdl/mgfe_ctrl.sv
// mgfe_ctrl: sequencer of the gain fade engine
// drives mgfe_datapath through the command and status types of mgfe_pkg
`timescale 1ns / 1ps

module mgfe_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mgfe_pkg::dp_status_type  status,
   output mgfe_pkg::dp_cmd_type     cmd
);

   mgfe_pkg::state_type state_ff, state_in;
   logic decode_blocked;
   logic step_blocked;
   logic is_tick;

   assign decode_blocked = (status.func == mgfe_pkg::FUNC_PLAY_FADE_UP) && status.ch_ok &&
                           !status.push_ok;
   assign step_blocked   = status.step_stop && !status.push_ok;
   assign is_tick        = (status.func == mgfe_pkg::FUNC_TICK);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mgfe_pkg::ST_IDLE: begin
            if (req_valid) state_in = mgfe_pkg::ST_DECODE;
         end
         mgfe_pkg::ST_DECODE: begin
            case (status.func)
               mgfe_pkg::FUNC_TICK:
                  state_in = status.count_zero ? mgfe_pkg::ST_FINISH : mgfe_pkg::ST_STEP;
               mgfe_pkg::FUNC_FADE_OUT, mgfe_pkg::FUNC_FADE_OUT_STOP:
                  state_in = status.ch_ok ? mgfe_pkg::ST_DIV : mgfe_pkg::ST_CUE;
               mgfe_pkg::FUNC_FADE_UP, mgfe_pkg::FUNC_PLAY_FADE_UP: begin
                  if (!decode_blocked) begin
                     state_in = status.ch_ok ? mgfe_pkg::ST_DIV : mgfe_pkg::ST_CUE;
                  end
               end
               mgfe_pkg::FUNC_SET_GAIN:
                  state_in = status.ch_ok ? mgfe_pkg::ST_MUL_A : mgfe_pkg::ST_FINISH;
               default:
                  state_in = mgfe_pkg::ST_FINISH;
            endcase
         end
         mgfe_pkg::ST_DIV: begin
            if (status.div_done) state_in = mgfe_pkg::ST_FADE_WR;
         end
         mgfe_pkg::ST_FADE_WR: state_in = mgfe_pkg::ST_CUE;
         mgfe_pkg::ST_CUE: begin
            if (!status.cue_ok || status.push_ok) state_in = mgfe_pkg::ST_FINISH;
         end
         mgfe_pkg::ST_STEP: begin
            if (!step_blocked) begin
               if (status.step_emit) begin
                  state_in = mgfe_pkg::ST_MUL_A;
               end else if (status.walk_last) begin
                  state_in = mgfe_pkg::ST_FINISH;
               end
            end
         end
         mgfe_pkg::ST_MUL_A: state_in = mgfe_pkg::ST_MUL_B;
         mgfe_pkg::ST_MUL_B: state_in = mgfe_pkg::ST_MUL_C;
         mgfe_pkg::ST_MUL_C: state_in = mgfe_pkg::ST_SEND;
         mgfe_pkg::ST_SEND: begin
            if (!status.gain_flag || status.push_ok) state_in = mgfe_pkg::ST_RESEND;
         end
         mgfe_pkg::ST_RESEND: begin
            if (!status.resend_flag || status.push_ok) begin
               state_in = (is_tick && !status.walk_last) ? mgfe_pkg::ST_STEP :
                                                           mgfe_pkg::ST_FINISH;
            end
         end
         mgfe_pkg::ST_FINISH: begin
            if (!status.pend_valid || status.flush_ok) state_in = mgfe_pkg::ST_IDLE;
         end
         default: state_in = mgfe_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.mul_sel   = mgfe_pkg::MUL_NONE;
      cmd.emit_kind = mgfe_pkg::KIND_GAIN;
      case (state_ff)
         mgfe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         mgfe_pkg::ST_DECODE: begin
            case (status.func)
               mgfe_pkg::FUNC_FADE_OUT, mgfe_pkg::FUNC_FADE_OUT_STOP:
                  cmd.div_start = status.ch_ok;
               mgfe_pkg::FUNC_FADE_UP, mgfe_pkg::FUNC_PLAY_FADE_UP: begin
                  if (!decode_blocked) begin
                     cmd.div_start = status.ch_ok;
                     if (status.func == mgfe_pkg::FUNC_PLAY_FADE_UP && status.ch_ok) begin
                        cmd.emit      = 1'b1;
                        cmd.emit_kind = mgfe_pkg::KIND_PLAY;
                     end
                  end
               end
               mgfe_pkg::FUNC_SET_GAIN:
                  cmd.set_gain = status.ch_ok;
               default: begin
               end
            endcase
         end
         mgfe_pkg::ST_FADE_WR: cmd.fade_write = 1'b1;
         mgfe_pkg::ST_CUE: begin
            if (status.cue_ok && status.push_ok) begin
               cmd.emit      = 1'b1;
               cmd.emit_kind = mgfe_pkg::KIND_PLAY;
               cmd.emit_cue  = 1'b1;
            end
         end
         mgfe_pkg::ST_STEP: begin
            if (!step_blocked) begin
               cmd.step_commit = 1'b1;
               cmd.advance     = !status.step_emit && !status.walk_last;
               if (status.step_stop) begin
                  cmd.emit      = 1'b1;
                  cmd.emit_kind = mgfe_pkg::KIND_STOP;
               end
            end
         end
         mgfe_pkg::ST_MUL_A: cmd.mul_sel = mgfe_pkg::MUL_GAIN_SQ;
         mgfe_pkg::ST_MUL_B: cmd.mul_sel = mgfe_pkg::MUL_GLOBAL_SQ;
         mgfe_pkg::ST_MUL_C: cmd.mul_sel = mgfe_pkg::MUL_PRODUCT;
         mgfe_pkg::ST_SEND: begin
            cmd.emit = status.gain_flag && status.push_ok;
         end
         mgfe_pkg::ST_RESEND: begin
            cmd.emit = status.resend_flag && status.push_ok;
            if (!status.resend_flag || status.push_ok) begin
               cmd.advance = is_tick && !status.walk_last;
            end
         end
         mgfe_pkg::ST_FINISH: begin
            if (!status.pend_valid || status.flush_ok) begin
               cmd.flush       = 1'b1;
               cmd.sync_global = is_tick;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mgfe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### hdl/mgfe_checker.sv
// mgfe_checker: port-level assertions for the gain fade engine, bound to the top level
// depends on mgfe_pkg for widths and result kinds
`timescale 1ns / 1ps

module mgfe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [mgfe_pkg::CHAN_W-1:0]  out_channel,
   input logic [mgfe_pkg::KIND_W-1:0]  out_kind,
   input logic [mgfe_pkg::GAIN_W-1:0]  out_gain,
   input logic                         out_last
);

   // one command at a time: no back-to-back transfers on the command side
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("command taken while previous one in progress");

   a_kind_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_kind == mgfe_pkg::KIND_GAIN) || (out_kind == mgfe_pkg::KIND_STOP) ||
                    (out_kind == mgfe_pkg::KIND_PLAY))
      else $error("unknown result kind");

   a_gain_only_on_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_kind != mgfe_pkg::KIND_GAIN) |-> (out_gain == '0))
      else $error("nonzero gain on stop or play");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_gain <= mgfe_pkg::UNITY))
      else $error("sent gain above unity");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_channel) && $stable(out_kind) &&
                                  $stable(out_gain) && $stable(out_last))
      else $error("stalled result changed");

endmodule

bind multichannel_gain_fade_engine_top mgfe_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .out_channel (rsp_bus.out_channel),
   .out_kind    (rsp_bus.out_kind),
   .out_gain    (rsp_bus.out_gain),
   .out_last    (rsp_bus.out_last)
);

### sim/mgfe_checker.sv
// mgfe_scoreboard: watches the command, result and register channels of the gain fade engine,
// predicts every result from its own copy of the channel state and compares in order
// depends on mgfe_pkg and the mgfe_req_if, mgfe_rsp_if and mgfe_csr_if interfaces
`timescale 1ns / 1ps

module mgfe_scoreboard #(
   parameter int CHANNELS = mgfe_pkg::CHANNELS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   mgfe_req_if  req_bus,
   mgfe_rsp_if  rsp_bus,
   mgfe_csr_if  csr_bus,
   output int   fail_count,
   output int   pending,
   output int   cmd_count,
   output int   result_count,
   output int   write_count
);

   localparam int CHAN_W    = mgfe_pkg::CHAN_W;
   localparam int GAIN_W    = mgfe_pkg::GAIN_W;
   localparam int STEP_W    = mgfe_pkg::STEP_W;
   localparam int TICKS_W   = mgfe_pkg::TICKS_W;
   localparam int COUNT_W   = mgfe_pkg::COUNT_W;
   localparam int FRAC_BITS = mgfe_pkg::FRAC_BITS;
   localparam logic [GAIN_W-1:0] UNITY = mgfe_pkg::UNITY;

   typedef struct packed {
      logic [CHAN_W-1:0]  chan;
      mgfe_pkg::kind_type kind;
      logic [GAIN_W-1:0]  gain;
      logic               last;
   } gain_event_type;

   logic [GAIN_W-1:0]        global_gain_reg;
   logic [COUNT_W-1:0]       chan_count_reg;
   logic [GAIN_W-1:0]        chan_gain   [CHANNELS];
   logic signed [STEP_W-1:0] fade_step   [CHANNELS];
   logic [GAIN_W-1:0]        fade_target [CHANNELS];
   mgfe_pkg::mode_type       fade_mode   [CHANNELS];
   logic                     stop_armed  [CHANNELS];
   logic [GAIN_W-1:0]        prev_global;

   gain_event_type batch_q[$];
   gain_event_type expected_q[$];

   int mismatches = 0;
   int n_cmds     = 0;
   int n_results  = 0;
   int n_writes   = 0;

   function automatic logic [GAIN_W-1:0] limit_unity(input logic [GAIN_W-1:0] v);
      return (v > UNITY) ? UNITY : v;
   endfunction

   // g^2 * G^2, each square truncated back to Q1.15
   function automatic logic [GAIN_W-1:0] scaled_gain(input logic [GAIN_W-1:0] g);
      logic [31:0] gu, gg, p, q, pq;
      gu = {16'd0, g};
      gg = {16'd0, limit_unity(global_gain_reg)};
      p  = (gu * gu) >> FRAC_BITS;
      q  = (gg * gg) >> FRAC_BITS;
      pq = (p * q) >> FRAC_BITS;
      return pq[GAIN_W-1:0];
   endfunction

   function automatic logic signed [STEP_W-1:0] fade_increment(
      input logic [GAIN_W-1:0]  amount,
      input logic [TICKS_W-1:0] ticks,
      input logic               down
   );
      logic [TICKS_W-1:0] t;
      logic [GAIN_W-1:0]  s;
      t = (ticks == '0) ? TICKS_W'(1) : ticks;
      s = amount / t;
      if (s == '0) s = GAIN_W'(1);
      return down ? -$signed({1'b0, s}) : $signed({1'b0, s});
   endfunction

   function automatic void add_event(input int ch, input mgfe_pkg::kind_type kind,
                                     input logic [GAIN_W-1:0] gain);
      gain_event_type e;
      e.chan = CHAN_W'(ch);
      e.kind = kind;
      e.gain = gain;
      e.last = 1'b0;
      batch_q.push_back(e);
   endfunction

   task automatic clear_model();
      global_gain_reg = UNITY;
      chan_count_reg  = '0;
      prev_global     = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         chan_gain[i]   = UNITY;
         fade_step[i]   = '0;
         fade_target[i] = UNITY;
         fade_mode[i]   = mgfe_pkg::MODE_IDLE;
         stop_armed[i]  = 1'b0;
      end
      expected_q.delete();
   endtask

   task automatic walk_tick();
      logic [GAIN_W-1:0] g_now;
      logic              changed;
      int                count;
      int                sum;
      g_now   = limit_unity(global_gain_reg);
      changed = (g_now != prev_global);
      count   = (int'(chan_count_reg) > CHANNELS) ? CHANNELS : int'(chan_count_reg);
      for (int i = 0; i < count; i++) begin
         if (fade_mode[i] == mgfe_pkg::MODE_OUT) begin
            sum = int'(chan_gain[i]) + int'(fade_step[i]);
            if (sum <= 0) begin
               sum          = 0;
               fade_mode[i] = mgfe_pkg::MODE_IDLE;
               if (stop_armed[i]) begin
                  add_event(i, mgfe_pkg::KIND_STOP, '0);
                  stop_armed[i] = 1'b0;
               end
            end
            chan_gain[i] = sum[GAIN_W-1:0];
            add_event(i, mgfe_pkg::KIND_GAIN, scaled_gain(chan_gain[i]));
         end
         if (fade_mode[i] == mgfe_pkg::MODE_UP) begin
            sum = int'(chan_gain[i]) + int'(fade_step[i]);
            if (sum >= int'(fade_target[i])) begin
               sum          = int'(fade_target[i]);
               fade_mode[i] = mgfe_pkg::MODE_IDLE;
            end
            chan_gain[i] = sum[GAIN_W-1:0];
            add_event(i, mgfe_pkg::KIND_GAIN, scaled_gain(chan_gain[i]));
         end
         // idle channels are resent only when the master gain moved
         if (changed && fade_mode[i] != mgfe_pkg::MODE_OUT && fade_mode[i] != mgfe_pkg::MODE_UP)
            add_event(i, mgfe_pkg::KIND_GAIN, scaled_gain(chan_gain[i]));
      end
      prev_global = g_now;
   endtask

   task automatic predict_cmd();
      logic [CHAN_W-1:0] ch, cue_ch;
      logic              ch_ok, cue_ok;
      logic [GAIN_W-1:0] target, ng;
      ch     = req_bus.channel;
      cue_ch = req_bus.cue_channel;
      ch_ok  = int'(ch) < CHANNELS;
      cue_ok = req_bus.cue_valid && (int'(cue_ch) < CHANNELS);
      target = limit_unity(req_bus.target_gain);
      ng     = limit_unity(req_bus.new_gain);
      batch_q.delete();
      case (req_bus.func)
         mgfe_pkg::FUNC_TICK: walk_tick();
         mgfe_pkg::FUNC_FADE_OUT, mgfe_pkg::FUNC_FADE_OUT_STOP: begin
            if (ch_ok) begin
               fade_step[ch]  = fade_increment(chan_gain[ch], req_bus.fade_ticks, 1'b1);
               fade_mode[ch]  = mgfe_pkg::MODE_OUT;
               stop_armed[ch] = (req_bus.func == mgfe_pkg::FUNC_FADE_OUT_STOP);
            end
            if (cue_ok) add_event(cue_ch, mgfe_pkg::KIND_PLAY, '0);
         end
         mgfe_pkg::FUNC_FADE_UP, mgfe_pkg::FUNC_PLAY_FADE_UP: begin
            if (req_bus.func == mgfe_pkg::FUNC_PLAY_FADE_UP && ch_ok)
               add_event(ch, mgfe_pkg::KIND_PLAY, '0);
            if (ch_ok) begin
               fade_step[ch]   = fade_increment(target, req_bus.fade_ticks, 1'b0);
               fade_mode[ch]   = mgfe_pkg::MODE_UP;
               stop_armed[ch]  = 1'b0;
               fade_target[ch] = target;
            end
            if (cue_ok) add_event(cue_ch, mgfe_pkg::KIND_PLAY, '0);
         end
         mgfe_pkg::FUNC_SET_GAIN: begin
            if (ch_ok) begin
               chan_gain[ch] = ng;
               add_event(ch, mgfe_pkg::KIND_GAIN, scaled_gain(ng));
            end
         end
         default: ;
      endcase
      if (batch_q.size() > 0) batch_q[batch_q.size()-1].last = 1'b1;
      foreach (batch_q[k]) expected_q.push_back(batch_q[k]);
   endtask

   task automatic check_result();
      gain_event_type seen, want;
      seen.chan = rsp_bus.out_channel;
      seen.kind = mgfe_pkg::kind_type'(rsp_bus.out_kind);
      seen.gain = rsp_bus.out_gain;
      seen.last = rsp_bus.out_last;
      n_results++;
      if (expected_q.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] unexpected result: ch %0d kind %0d gain %0d last %0b",
                     $time, seen.chan, seen.kind, seen.gain, seen.last);
      end else begin
         want = expected_q.pop_front();
         if (seen !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"[%0t] result mismatch: expected ch %0d kind %0d gain %0d last %0b,",
                         " got ch %0d kind %0d gain %0d last %0b"},
                        $time, want.chan, want.kind, want.gain, want.last,
                        seen.chan, seen.kind, seen.gain, seen.last);
         end
      end
   endtask

   // register writes, then commands, then results: results always match older commands
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            n_writes++;
            case (csr_bus.index)
               mgfe_pkg::CSR_GLOBAL_GAIN:     global_gain_reg = csr_bus.data;
               mgfe_pkg::CSR_CHANNELS_IN_USE: chan_count_reg  = csr_bus.data[COUNT_W-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            n_cmds++;
            predict_cmd();
         end
         if (rsp_bus.valid && rsp_bus.ready) check_result();
      end
      fail_count   <= mismatches;
      pending      <= expected_q.size();
      cmd_count    <= n_cmds;
      result_count <= n_results;
      write_count  <= n_writes;
   end

endmodule

### sim/multichannel_gain_fade_engine_top_tb.sv
// multichannel_gain_fade_engine_top_tb: drives commands and register settings into the
// gain fade engine with random idling on both sides and gives the verdict
// depends on mgfe_pkg, the three channel interfaces, mgfe_scoreboard and the engine top level
`timescale 1ns / 1ps

module multichannel_gain_fade_engine_top_tb;

   localparam int FUNC_W     = mgfe_pkg::FUNC_W;
   localparam int CHAN_W     = mgfe_pkg::CHAN_W;
   localparam int TICKS_W    = mgfe_pkg::TICKS_W;
   localparam int GAIN_W     = mgfe_pkg::GAIN_W;
   localparam int COUNT_W    = mgfe_pkg::COUNT_W;
   localparam int CSR_DATA_W = mgfe_pkg::CSR_DATA_W;
   localparam logic [GAIN_W-1:0] UNITY = mgfe_pkg::UNITY;

   localparam int ITEMS        = 460;
   localparam int PHASES       = 6;
   localparam int DRAIN_CYCLES = 120;
   localparam int IDLE_PCT     = 16;

   // func codes the engine ignores
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [CHAN_W-1:0]  channel;
      logic [TICKS_W-1:0] fade_ticks;
      logic [GAIN_W-1:0]  target_gain;
      logic [GAIN_W-1:0]  new_gain;
      logic               cue_valid;
      logic [CHAN_W-1:0]  cue_channel;
   } fade_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm  = 1'b0;

   int fail_count;
   int pending;
   int cmd_count;
   int result_count;
   int write_count;
   int phase_count = 0;

   mgfe_req_if req_bus ();
   mgfe_rsp_if rsp_bus ();
   mgfe_csr_if csr_bus ();

   multichannel_gain_fade_engine_top u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   mgfe_scoreboard u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .rsp_bus      (rsp_bus),
      .csr_bus      (csr_bus),
      .fail_count   (fail_count),
      .pending      (pending),
      .cmd_count    (cmd_count),
      .result_count (result_count),
      .write_count  (write_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   initial begin
      #30_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic fade_cmd_type make_cmd(
      input logic [FUNC_W-1:0]  func,
      input logic [CHAN_W-1:0]  ch,
      input logic [TICKS_W-1:0] ticks,
      input logic [GAIN_W-1:0]  target,
      input logic [GAIN_W-1:0]  ng,
      input logic               cue_v,
      input logic [CHAN_W-1:0]  cue_ch
   );
      fade_cmd_type c;
      c.func        = func;
      c.channel     = ch;
      c.fade_ticks  = ticks;
      c.target_gain = target;
      c.new_gain    = ng;
      c.cue_valid   = cue_v;
      c.cue_channel = cue_ch;
      return c;
   endfunction

   function automatic logic [GAIN_W-1:0] rand_gain();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return UNITY;
         2:       return GAIN_W'($urandom_range(32769, 65535));
         3:       return GAIN_W'($urandom_range(0, 255));
         default: return GAIN_W'($urandom_range(0, 32768));
      endcase
   endfunction

   // mostly short fades so that many of them finish within a phase
   function automatic logic [TICKS_W-1:0] rand_ticks();
      case ($urandom_range(0, 6))
         0:       return '0;
         1:       return '1;
         5:       return TICKS_W'($urandom_range(1, 64));
         6:       return TICKS_W'($urandom);
         default: return TICKS_W'($urandom_range(1, 8));
      endcase
   endfunction

   function automatic fade_cmd_type rand_cmd();
      fade_cmd_type c;
      int           r;
      r = $urandom_range(0, 99);
      if (r < 35)      c.func = mgfe_pkg::FUNC_TICK;
      else if (r < 47) c.func = mgfe_pkg::FUNC_FADE_OUT;
      else if (r < 59) c.func = mgfe_pkg::FUNC_FADE_OUT_STOP;
      else if (r < 69) c.func = mgfe_pkg::FUNC_FADE_UP;
      else if (r < 79) c.func = mgfe_pkg::FUNC_PLAY_FADE_UP;
      else if (r < 95) c.func = mgfe_pkg::FUNC_SET_GAIN;
      else             c.func = $urandom_range(0, 1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
      c.channel     = CHAN_W'($urandom_range(0, 15));
      c.fade_ticks  = rand_ticks();
      c.target_gain = rand_gain();
      c.new_gain    = rand_gain();
      c.cue_valid   = 1'($urandom_range(0, 1));
      c.cue_channel = CHAN_W'($urandom_range(0, 15));
      return c;
   endfunction

   task automatic send_cmd(input fade_cmd_type c);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= c.func;
      req_bus.channel     <= c.channel;
      req_bus.fade_ticks  <= c.fade_ticks;
      req_bus.target_gain <= c.target_gain;
      req_bus.new_gain    <= c.new_gain;
      req_bus.cue_valid   <= c.cue_valid;
      req_bus.cue_channel <= c.cue_channel;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // commands without results leave no trace in the checker, hence the fixed pause
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_regs(input logic [GAIN_W-1:0] gain, input logic [COUNT_W-1:0] count);
      drain();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= mgfe_pkg::CSR_GLOBAL_GAIN;
      csr_bus.data  <= gain;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.index <= mgfe_pkg::CSR_CHANNELS_IN_USE;
      csr_bus.data  <= CSR_DATA_W'(count);
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      phase_count++;
   endtask

   initial begin
      fade_cmd_type c;
      int           items_done;
      items_done          = 0;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= mgfe_pkg::FUNC_TICK;
      req_bus.channel     <= '0;
      req_bus.fade_ticks  <= '0;
      req_bus.target_gain <= '0;
      req_bus.new_gain    <= '0;
      req_bus.cue_valid   <= 1'b0;
      req_bus.cue_channel <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= mgfe_pkg::CSR_GLOBAL_GAIN;
      csr_bus.data        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: no channels walked, oversized set gain, ignored codes
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_SET_GAIN, 0, 0, 0, 16'hFFFF, 0, 0));
      send_cmd(make_cmd(FUNC_UNUSED_LO, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 15));
      send_cmd(make_cmd(FUNC_UNUSED_HI, 15, 1, 1, 1, 1, 1));

      // oversized master gain saturates to unity, so nothing is resent
      set_regs(16'hFFFF, 5'd31);
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_FADE_OUT, 0, 0, 0, 0, 1, 15));
      send_cmd(make_cmd(mgfe_pkg::FUNC_FADE_OUT_STOP, 1, 16'hFFFF, 0, 0, 0, 15));
      send_cmd(make_cmd(mgfe_pkg::FUNC_FADE_UP, 2, 3, 16'hFFFF, 0, 1, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_SET_GAIN, 3, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_PLAY_FADE_UP, 3, 1000, 100, 0, 1, 3));
      send_cmd(make_cmd(mgfe_pkg::FUNC_SET_GAIN, 4, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_FADE_OUT_STOP, 4, 5, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_FADE_UP, 5, 1, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));

      // zero master gain, a single channel walked
      set_regs(16'd0, 5'd1);
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_SET_GAIN, 0, 0, 0, 12345, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_FADE_OUT_STOP, 0, 2, 0, 0, 1, 7));
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));

      set_regs(16'd1, 5'd16);
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_SET_GAIN, 15, 0, 0, UNITY, 0, 0));
      send_cmd(make_cmd(mgfe_pkg::FUNC_TICK, 0, 0, 0, 0, 0, 0));

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       set_regs(UNITY, 5'd16);
            1:       set_regs(16'd0, 5'd31);
            2:       set_regs(GAIN_W'($urandom_range(0, 32768)), COUNT_W'($urandom_range(0, 16)));
            3:       set_regs(16'hFFFF, 5'd16);
            4:       set_regs(16'd1, COUNT_W'($urandom_range(17, 31)));
            default: set_regs(GAIN_W'($urandom), COUNT_W'($urandom_range(0, 31)));
         endcase
         // one whole phase runs without idling on either side
         calm <= (p == 2);
         while (items_done < (ITEMS * (p + 1)) / PHASES) begin
            c = rand_cmd();
            send_cmd(c);
            items_done++;
         end
      end

      drain();
      $display("run covered %0d commands under %0d register settings (%0d register writes)",
               cmd_count, phase_count, write_count);
      $display("%0d results compared against the predicted gain, stop and play stream",
               result_count);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
